>>> design/b64_pkg.sv
`timescale 1ns / 1ps

package b64_pkg;

    localparam int B64_QUEUE_DEPTH = 2;

    localparam logic [7:0] CHAR_PAD = 8'h3D;

    // Character classes returned by char_value beyond the 64 symbol values.
    localparam logic [6:0] CV_PAD = 7'd64;
    localparam logic [6:0] CV_BAD = 7'd65;

    typedef struct packed {
        logic [7:0] data_in;
        logic       is_last;
    } t_in;

    typedef struct packed {
        logic [7:0] data_out;
        logic       last_out;
        logic       bad_char;
    } t_out;

    // One accepted item's worth of results, 1 to 4 of them.
    typedef struct packed {
        logic [2:0]      count;
        t_out [3:0]      res;
    } t_job;

    function automatic logic [7:0] sym(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26) begin
            sym = w + 8'h41;
        end else if (v < 6'd52) begin
            sym = w + 8'h47;
        end else if (v < 6'd62) begin
            sym = w - 8'd4;
        end else if (v == 6'd62) begin
            sym = 8'h2B;
        end else begin
            sym = 8'h2F;
        end
    endfunction

    function automatic logic [6:0] char_value(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A) begin
            char_value = 7'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            char_value = 7'(c - 8'h47);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            char_value = 7'(c + 8'd4);
        end else if (c == 8'h2B) begin
            char_value = 7'd62;
        end else if (c == 8'h2F) begin
            char_value = 7'd63;
        end else if (c == CHAR_PAD) begin
            char_value = CV_PAD;
        end else begin
            char_value = CV_BAD;
        end
    endfunction

endpackage

>>> design/base64_stream_codec.sv
`timescale 1ns / 1ps
// A result is held in the job queue and then in the output register before it is presented.
// Throughput: one result per cycle out while the output is not stalled; an item yields 1 to 4
// results (none for a decode item that completes no byte), drained from the job queue by the
// single output register. Input is taken every cycle the queue has room.
// Reset (synchronous, active low) selects encode mode and clears stream state and queue.
module base64_stream_codec #(
    parameter int QUEUE_DEPTH = b64_pkg::B64_QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic          i_cfg_wr_data,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  b64_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output b64_pkg::t_out o_out_data
);
    import b64_pkg::*;

    logic w_full;
    logic w_accept;
    logic w_push;
    t_job w_push_job;
    logic w_q_valid;
    t_job w_q_head;
    logic w_pop;

    assign o_in_stall = w_full;
    assign w_accept   = i_in_valid && !w_full;

    b64_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (w_accept),
        .i_item        (i_in_data),
        .o_push        (w_push),
        .o_job         (w_push_job)
    );

    b64_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_job (w_push_job),
        .o_full     (w_full),
        .o_valid    (w_q_valid),
        .o_head     (w_q_head),
        .i_pop      (w_pop)
    );

    b64_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_head    (w_q_head),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

>>> design/b64_front.sv
`timescale 1ns / 1ps

module b64_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic          i_cfg_wr_data,
    input  logic          i_accept,
    input  b64_pkg::t_in  i_item,
    output logic          o_push,
    output b64_pkg::t_job o_job
);
    import b64_pkg::*;

    logic       r_mode;
    logic [1:0] r_phase;
    logic [5:0] r_carry;
    logic [1:0] r_pad;
    logic       r_err;

    logic [1:0] n_phase;
    logic [5:0] n_carry;
    logic [1:0] n_pad;
    logic       n_err;

    t_out [3:0] w_res;
    logic [2:0] w_n;
    logic [7:0] w_b;
    logic [6:0] w_v;
    logic       w_bad;

    always_comb begin
        w_b     = i_item.data_in;
        w_v     = char_value(w_b);
        w_res   = '0;
        w_n     = 3'd0;
        w_bad   = 1'b0;
        n_phase = r_phase;
        n_carry = r_carry;
        n_pad   = r_pad;
        n_err   = r_err;
        if (!r_mode) begin
            case (r_phase)
                2'd0: begin
                    w_res[0].data_out = sym(w_b[7:2]);
                    n_carry = {w_b[1:0], 4'b0000};
                    n_phase = 2'd1;
                    w_n     = 3'd1;
                end
                2'd1: begin
                    w_res[0].data_out = sym(r_carry | {2'b00, w_b[7:4]});
                    n_carry = {w_b[3:0], 2'b00};
                    n_phase = 2'd2;
                    w_n     = 3'd1;
                end
                default: begin
                    w_res[0].data_out = sym(r_carry | {4'b0000, w_b[7:6]});
                    w_res[1].data_out = sym(w_b[5:0]);
                    n_carry = 6'd0;
                    n_phase = 2'd0;
                    w_n     = 3'd2;
                end
            endcase
            // Flush of a partial group: the phase is then 1 or 2 and one symbol is out.
            if (i_item.is_last && n_phase != 2'd0) begin
                w_res[1].data_out = sym(n_carry);
                w_res[2].data_out = CHAR_PAD;
                w_n = 3'd3;
                if (n_phase == 2'd1) begin
                    w_res[3].data_out = CHAR_PAD;
                    w_n = 3'd4;
                end
            end
        end else begin
            if (r_err || w_v == CV_BAD) begin
                w_bad = 1'b1;
            end else if (w_v == CV_PAD) begin
                w_bad = (r_phase < 2'd2);
                if (!w_bad) begin
                    n_pad   = r_pad + 2'd1;
                    n_phase = r_phase + 2'd1;
                    n_carry = 6'd0;
                end
            end else if (r_pad != 2'd0) begin
                w_bad = 1'b1;
            end else begin
                case (r_phase)
                    2'd0: begin
                        n_carry = w_v[5:0];
                    end
                    2'd1: begin
                        w_res[0].data_out = {r_carry, w_v[5:4]};
                        n_carry = {2'b00, w_v[3:0]};
                        w_n     = 3'd1;
                    end
                    2'd2: begin
                        w_res[0].data_out = {r_carry[3:0], w_v[5:2]};
                        n_carry = {4'b0000, w_v[1:0]};
                        w_n     = 3'd1;
                    end
                    default: begin
                        w_res[0].data_out = {r_carry[1:0], w_v[5:0]};
                        n_carry = 6'd0;
                        w_n     = 3'd1;
                    end
                endcase
                n_phase = r_phase + 2'd1;
            end
            if (w_bad) begin
                n_err = 1'b1;
                w_res[0].data_out = 8'd0;
                w_res[0].bad_char = 1'b1;
                w_n = 3'd1;
            end
        end
        if (w_n != 3'd0) begin
            w_res[2'(w_n - 3'd1)].last_out = 1'b1;
        end
        if (i_item.is_last) begin
            n_phase = 2'd0;
            n_carry = 6'd0;
            n_pad   = 2'd0;
            n_err   = 1'b0;
        end
    end

    assign o_push      = i_accept && (w_n != 3'd0);
    assign o_job.count = w_n;
    assign o_job.res   = w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b0;
            r_phase <= 2'd0;
            r_carry <= 6'd0;
            r_pad   <= 2'd0;
            r_err   <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_mode  <= i_cfg_wr_data;
            r_phase <= 2'd0;
            r_carry <= 6'd0;
            r_pad   <= 2'd0;
            r_err   <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_carry <= n_carry;
            r_pad   <= n_pad;
            r_err   <= n_err;
        end
    end

endmodule

>>> design/b64_queue.sv
`timescale 1ns / 1ps

module b64_queue #(
    parameter int DEPTH = b64_pkg::B64_QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  b64_pkg::t_job i_push_job,
    output logic          o_full,
    output logic          o_valid,
    output b64_pkg::t_job o_head,
    input  logic          i_pop
);
    import b64_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

>>> design/b64_back.sv
`timescale 1ns / 1ps

module b64_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  b64_pkg::t_job i_q_head,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output b64_pkg::t_out o_out_data
);
    import b64_pkg::*;

    logic       r_out_valid;
    t_out       r_out;
    logic [1:0] r_idx;

    logic w_load_ok;
    logic w_take;
    logic w_final;

    assign w_load_ok = !r_out_valid || !i_out_stall;
    assign w_take    = w_load_ok && i_q_valid;
    assign w_final   = ({1'b0, r_idx} == (i_q_head.count - 3'd1));
    assign o_pop     = w_take && w_final;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out <= i_q_head.res[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= 2'd0;
        end else begin
            if (w_take) begin
                r_out_valid <= 1'b1;
                r_idx       <= w_final ? 2'd0 : r_idx + 2'd1;
            end else if (w_load_ok) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_job_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_valid |-> (i_q_head.count != 3'd0 && i_q_head.count <= 3'd4))
        else $error("queued job has an impossible result count");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_valid |-> ({1'b0, r_idx} < i_q_head.count))
        else $error("result index runs past the job's count");

    a_idx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_q_valid |-> (r_idx == 2'd0))
        else $error("result index left nonzero with no job queued");

    a_pop_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (o_out_valid && o_out_data.last_out))
        else $error("popping a job did not present its final result");

endmodule
